// File: rtl/mm2p1_pkg.sv
package mm2p1_pkg;

  // Modulus is 2^MOD_BITS + 1; the operand fields are exactly this wide.
  localparam int MOD_BITS = 32;

  // Bit positions inside top_flags.
  localparam int FLAG_Y = 1;
  localparam int FLAG_Z = 0;

  // Beat on the operand channel.
  typedef struct packed {
    logic [MOD_BITS-1:0] y_low;
    logic [MOD_BITS-1:0] z_low;
    logic [1:0]          top_flags;
  } operand_t;

  // Beat on the result channel.
  typedef struct packed {
    logic [MOD_BITS-1:0] result_low;
    logic                result_top;
  } result_t;

  // After the multiply stage: full product, or the finished special-case value.
  typedef struct packed {
    logic                  is_mul;
    logic [2*MOD_BITS-1:0] product;
    logic [MOD_BITS-1:0]   spec_low;
    logic                  spec_top;
  } prod_t;

  // After the fold stage: low half minus high half, borrow in the top bit.
  typedef struct packed {
    logic                is_mul;
    logic [MOD_BITS:0]   diff;
    logic [MOD_BITS-1:0] spec_low;
    logic                spec_top;
  } fold_t;

endpackage

// File: rtl/mulmod_two_pow_b_plus_one.sv
// Multiplier for residues modulo 2^B + 1 (B = 32), fully reduced output.
//
// Operand channel: operands carries y_low, z_low and top_flags; a beat moves
// when operand_valid is high and operand_stall is low. A set flag marks an
// operand equal to 2^B (its low part is ignored).
// Result channel: result carries result_low and result_top; a beat moves when
// result_valid is high and result_stall is low. result_top marks 2^B.
//
// Pipeline: three register stages (multiply, fold, final correction).
// Throughput is one beat per cycle when nothing stalls; the 32x32 multiply
// sets the stage depth.
//
// Reset clears all stage valid bits; the block then takes a beat at once.
// When the receiver stalls, the result register holds and earlier stages
// keep filling their empty slots, so up to three beats are absorbed before
// operand_stall rises. Nothing is dropped or repeated.
module mulmod_two_pow_b_plus_one import mm2p1_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     operand_valid,
  output logic     operand_stall,
  input  operand_t operands,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  logic    mul_valid;
  logic    mul_stall;
  prod_t   mul_beat;
  logic    fold_valid;
  logic    fold_stall;
  fold_t   fold_beat;
  logic    advance;
  result_t result_next;

  // Stage 1: product and special-case negation.
  mm2p1_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operand_valid),
    .in_stall  (operand_stall),
    .in_beat   (operands),
    .out_valid (mul_valid),
    .out_stall (mul_stall),
    .out_beat  (mul_beat)
  );

  // Stage 2: low half minus high half.
  mm2p1_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_stall  (mul_stall),
    .in_beat   (mul_beat),
    .out_valid (fold_valid),
    .out_stall (fold_stall),
    .out_beat  (fold_beat)
  );

  // Stage 3: the result register; advance whenever it is empty or drained.
  assign advance    = !result_valid || !result_stall;
  assign fold_stall = !advance;

  // On a borrow add one back (mod 2^B+1); a difference of -1 is exactly 2^B.
  always_comb begin
    result_next.result_low = fold_beat.spec_low;
    result_next.result_top = fold_beat.spec_top;
    if (fold_beat.is_mul) begin
      if (!fold_beat.diff[MOD_BITS]) begin
        result_next.result_low = fold_beat.diff[MOD_BITS-1:0];
        result_next.result_top = 1'b0;
      end else if (&fold_beat.diff[MOD_BITS-1:0]) begin
        result_next.result_low = '0;
        result_next.result_top = 1'b1;
      end else begin
        result_next.result_low = fold_beat.diff[MOD_BITS-1:0] + MOD_BITS'(1);
        result_next.result_top = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fold_valid;
    end
  end

  // Hold the payload while stalled; load only real beats.
  always_ff @(posedge clk) begin
    if (advance && fold_valid) begin
      result <= result_next;
    end
  end

  // A residue of 2^B always has a zero low part.
  a_top_low_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_top |-> result.result_low == '0)
    else $error("result_top set with nonzero result_low");

  // The input side stalls only when every stage is full and the output waits.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    operand_stall |-> mul_valid && fold_valid && result_valid && result_stall)
    else $error("operand_stall raised with a free pipeline slot");

  // A beat in the fold stage that is blocked must still be there next cycle.
  a_fold_held: assert property (@(posedge clk) disable iff (rst)
    fold_valid && fold_stall |=> fold_valid && $stable(fold_beat))
    else $error("fold stage lost or changed a blocked beat");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result_valid high right after reset");

endmodule

// File: rtl/mm2p1_mul.sv
module mm2p1_mul import mm2p1_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  operand_t in_beat,
  output logic     out_valid,
  input  logic     out_stall,
  output prod_t    out_beat
);

  logic  advance;
  prod_t beat_next;
  logic  fy;
  logic  fz;

  // Negation mod 2^B+1 of a reduced low part: 0 stays 0, 1 becomes 2^B.
  function automatic logic [MOD_BITS:0] negate(input logic [MOD_BITS-1:0] v);
    logic [MOD_BITS:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v == MOD_BITS'(1)) begin
      r = {MOD_BITS'(0), 1'b1};
    end else begin
      r = {(~v + MOD_BITS'(2)), 1'b0};
    end
    return r;
  endfunction

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  assign fy = in_beat.top_flags[FLAG_Y];
  assign fz = in_beat.top_flags[FLAG_Z];

  always_comb begin
    beat_next.is_mul  = !fy && !fz;
    beat_next.product = {{MOD_BITS{1'b0}}, in_beat.y_low} *
                        {{MOD_BITS{1'b0}}, in_beat.z_low};
    {beat_next.spec_low, beat_next.spec_top} = '0;
    if (fy && fz) begin
      beat_next.spec_low = MOD_BITS'(1);
    end else if (fz) begin
      {beat_next.spec_low, beat_next.spec_top} = negate(in_beat.y_low);
    end else if (fy) begin
      {beat_next.spec_low, beat_next.spec_top} = negate(in_beat.z_low);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

// File: rtl/mm2p1_fold.sv
module mm2p1_fold import mm2p1_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  prod_t in_beat,
  output logic  out_valid,
  input  logic  out_stall,
  output fold_t out_beat
);

  logic  advance;
  fold_t beat_next;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Fold: 2^B == -1, so low half minus high half.
  always_comb begin
    beat_next.is_mul   = in_beat.is_mul;
    beat_next.diff     = {1'b0, in_beat.product[MOD_BITS-1:0]} -
                         {1'b0, in_beat.product[2*MOD_BITS-1:MOD_BITS]};
    beat_next.spec_low = in_beat.spec_low;
    beat_next.spec_top = in_beat.spec_top;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule
